FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the governor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, ck, rstn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (expr)) \
		else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, ck, rstn, expr)
`define ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

FILE: hw/rtl/lbfg_pkg.sv
// Shared constants, types and codes of the load based frequency governor.
`timescale 1ns / 1ps

package lbfg_pkg;

	localparam int NUM_CORES  = 8;
	localparam int CORE_W     = 3;
	localparam int CNT_W      = 64;
	localparam int FREQ_W     = 24;
	localparam int HOLD_W     = 17;
	localparam int PCT_W      = 7;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int DELTA_W = 32;
	localparam int DBIT_W  = $clog2(DELTA_W);
	localparam int LOAD_W  = 7;
	localparam int NUM_W   = DELTA_W + LOAD_W;
	localparam int LF_W    = 32;
	localparam int LCNT_W  = $clog2(LOAD_W);
	localparam int TCNT_W  = $clog2(FREQ_W);

	localparam logic [CORE_W:0]       CORE_LIM   = (CORE_W + 1)'(NUM_CORES);
	localparam logic [DBIT_W-1:0]     BIT_LAST   = DBIT_W'(DELTA_W - 1);
	localparam logic [LCNT_W-1:0]     LDIV_LAST  = LCNT_W'(LOAD_W - 1);
	localparam logic [TCNT_W-1:0]     TDIV_LAST  = TCNT_W'(FREQ_W - 1);
	localparam logic [PCT_W-1:0]      LOAD_SCALE = PCT_W'(100);
	localparam logic [HOLD_W-1:0]     HOLD_MAX   = HOLD_W'(100000);
	localparam logic [HOLD_W-1:0]     HOLD_ONE   = HOLD_W'(1);

	localparam logic [PCT_W-1:0]  UP_RST   = PCT_W'(60);
	localparam logic [PCT_W-1:0]  DD_RST   = PCT_W'(20);
	localparam logic [FREQ_W-1:0] FMIN_RST = '0;
	localparam logic [FREQ_W-1:0] FMAX_RST = '1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_PRIME  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_THRESHOLD = 3'd0,
		REG_DOWN_DIFF    = 3'd1,
		REG_NICE_IDLE    = 3'd2,
		REG_IOW_BUSY     = 3'd3,
		REG_HOLD_FACTOR  = 3'd4,
		REG_FREQ_MIN     = 3'd5,
		REG_FREQ_MAX     = 3'd6
	} cfg_reg_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE  = 2'd0,
		ACT_RAISE = 2'd1,
		ACT_LOWER = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SERIAL,
		ST_PREP,
		ST_LDIV,
		ST_ACC,
		ST_CHECK,
		ST_DEC1,
		ST_DEC2,
		ST_TDIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic done;
		logic usable;
	} delta_stat_t;

endpackage

FILE: hw/rtl/lbfg_if.sv
// Sample and result channel interfaces of the governor.
`timescale 1ns / 1ps

interface lbfg_sample_if;
	import lbfg_pkg::*;

	logic                valid;
	logic                ready;
	logic                cmd;
	logic [CORE_W-1:0]   core_index;
	logic [CNT_W-1:0]    wall_us;
	logic [CNT_W-1:0]    idle_us;
	logic [CNT_W-1:0]    iowait_us;
	logic [CNT_W-1:0]    nice_us;
	logic [FREQ_W-1:0]   avg_freq_khz;
	logic [FREQ_W-1:0]   cur_freq_khz;
	logic                last_core;

	modport source (
		output valid, cmd, core_index, wall_us, idle_us, iowait_us, nice_us,
		output avg_freq_khz, cur_freq_khz, last_core,
		input ready
	);

	modport sink (
		input valid, cmd, core_index, wall_us, idle_us, iowait_us, nice_us,
		input avg_freq_khz, cur_freq_khz, last_core,
		output ready
	);
endinterface

interface lbfg_result_if;
	import lbfg_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACT_W-1:0]    action;
	logic [FREQ_W-1:0]   target_khz;
	logic [HOLD_W-1:0]   rate_multiplier;

	modport source (
		output valid, action, target_khz, rate_multiplier,
		input ready
	);

	modport sink (
		input valid, action, target_khz, rate_multiplier,
		output ready
	);
endinterface

FILE: hw/rtl/load_based_frequency_governor.sv
// Load based frequency governor top level: per-core load tracking and round decision.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One item is one core sample. A prime item only records the baseline counters. For a
// sample item the four counter deltas and the busy time are formed one bit per cycle and
// handed over, then come a setup step, a 7-step restoring division for the load percent,
// a step that scales it by the core frequency and folds it into the peak, and a check
// step. A sample with zero wall time or idle time above wall time skips the division. An
// item marked last core adds the decision steps DEC1 and DEC2, then, when the target is
// lowered, a 24-step division of the peak load-frequency by the threshold difference,
// and the emit step. The result register frees the input side: the next item is taken
// while a result still waits; a new decision waits only for that register to empty.
module load_based_frequency_governor (
	input  logic                               clk,
	input  logic                               arst_n,
	lbfg_sample_if.sink                        sample,
	lbfg_result_if.source                      result,
	input  logic                               wr_en,
	input  logic [lbfg_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [lbfg_pkg::CFG_DATA_W-1:0]    wr_data
);
	import lbfg_pkg::*;

	// configuration
	logic [PCT_W-1:0]  up_q, dd_q;
	logic              ign_q, iob_q;
	logic [HOLD_W-1:0] hold_q;
	logic [FREQ_W-1:0] fmin_q, fmax_q;

	// per-core baseline, low half only (deltas are modulo 2^32)
	logic [DELTA_W-1:0] prev_wall_q [NUM_CORES];
	logic [DELTA_W-1:0] prev_idle_q [NUM_CORES];
	logic [DELTA_W-1:0] prev_iow_q  [NUM_CORES];
	logic [DELTA_W-1:0] prev_nice_q [NUM_CORES];

	state_t state_q, state_d;

	logic [FREQ_W-1:0]  cur_q, favg_q;
	logic               last_q;
	logic [NUM_W-1:0]   num_q, den_q;
	logic [LOAD_W-1:0]  load_q;
	logic [LCNT_W-1:0]  lcnt_q;
	logic [LF_W-1:0]    mlf_q, prod_q;
	logic               raise_q;
	logic [HOLD_W-1:0]  rate_q;
	logic [PCT_W-1:0]   trem_q;
	logic [FREQ_W-1:0]  tnum_q, tquo_q, dec_tgt_q;
	logic [TCNT_W-1:0]  tcnt_q;
	action_t            dec_act_q, res_action_q;
	logic [FREQ_W-1:0]  res_target_q;
	logic [HOLD_W-1:0]  res_rate_q;
	logic               out_valid_q;

	logic               accept, in_range, rec_en, delta_start, emit_fire, lower_go;
	logic [DELTA_W-1:0] dwall, dbusy;
	delta_stat_t        dstat;
	logic [PCT_W-1:0]   diff;
	logic               ld_ge, td_ge;
	logic [PCT_W:0]     td_trial, td_rem;
	logic [LF_W-1:0]    lf;
	logic [HOLD_W-1:0]  hold_eff;
	logic [FREQ_W-1:0]  lower_tgt;

	assign accept      = sample.valid && sample.ready;
	assign in_range    = {1'b0, sample.core_index} < CORE_LIM;
	assign rec_en      = accept && in_range;
	assign delta_start = rec_en && (sample.cmd == CMD_SAMPLE);
	assign diff        = up_q - dd_q;
	assign ld_ge       = num_q >= den_q;
	assign td_trial    = {trem_q, tnum_q[FREQ_W-1]};
	assign td_ge       = td_trial >= {1'b0, diff};
	assign td_rem      = td_ge ? (td_trial - {1'b0, diff}) : td_trial;
	assign lf          = LF_W'(load_q) * LF_W'(favg_q);
	assign lower_go    = !raise_q && (cur_q != fmin_q) && (dd_q < up_q) && (mlf_q < prod_q);
	assign lower_tgt   = (tquo_q < fmin_q) ? fmin_q : tquo_q;
	assign hold_eff    = (hold_q == '0) ? HOLD_ONE : ((hold_q > HOLD_MAX) ? HOLD_MAX : hold_q);

	lbfg_delta u_delta (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (delta_start),
		.nice_idle   (ign_q),
		.iow_busy    (iob_q),
		.cur_wall    (sample.wall_us[DELTA_W-1:0]),
		.prev_wall   (prev_wall_q[sample.core_index]),
		.cur_idle    (sample.idle_us[DELTA_W-1:0]),
		.prev_idle   (prev_idle_q[sample.core_index]),
		.cur_iow     (sample.iowait_us[DELTA_W-1:0]),
		.prev_iow    (prev_iow_q[sample.core_index]),
		.now_nice    (sample.nice_us[DELTA_W-1:0]),
		.prev_nice   (prev_nice_q[sample.core_index]),
		.wall        (dwall),
		.busy        (dbusy),
		.stat        (dstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		emit_fire = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample.valid && (sample.cmd == CMD_SAMPLE)) begin
					state_d = in_range ? ST_SERIAL : ST_CHECK;
				end
			end
			ST_SERIAL: begin
				if (dstat.done) begin
					state_d = dstat.usable ? ST_PREP : ST_CHECK;
				end
			end
			ST_PREP: state_d = ST_LDIV;
			ST_LDIV: begin
				if (lcnt_q == LDIV_LAST) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC:   state_d = ST_CHECK;
			ST_CHECK: state_d = last_q ? ST_DEC1 : ST_IDLE;
			ST_DEC1:  state_d = ST_DEC2;
			ST_DEC2:  state_d = lower_go ? ST_TDIV : ST_EMIT;
			ST_TDIV: begin
				if (tcnt_q == TDIV_LAST) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || result.ready) begin
					emit_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration, division counters, peak load-frequency, multiplier, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q        <= UP_RST;
			dd_q        <= DD_RST;
			ign_q       <= 1'b0;
			iob_q       <= 1'b0;
			hold_q      <= HOLD_ONE;
			fmin_q      <= FMIN_RST;
			fmax_q      <= FMAX_RST;
			rate_q      <= HOLD_ONE;
			mlf_q       <= '0;
			out_valid_q <= 1'b0;
			lcnt_q      <= '0;
			tcnt_q      <= '0;
		end else begin
			if (wr_en) begin
				unique case (cfg_reg_t'(wr_index))
					REG_UP_THRESHOLD: up_q   <= wr_data[PCT_W-1:0];
					REG_DOWN_DIFF:    dd_q   <= wr_data[PCT_W-1:0];
					REG_NICE_IDLE:    ign_q  <= wr_data[0];
					REG_IOW_BUSY:     iob_q  <= wr_data[0];
					REG_HOLD_FACTOR: begin
						hold_q <= wr_data[HOLD_W-1:0];
						rate_q <= HOLD_ONE;
					end
					REG_FREQ_MIN:     fmin_q <= wr_data[FREQ_W-1:0];
					REG_FREQ_MAX:     fmax_q <= wr_data[FREQ_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_PREP) begin
				lcnt_q <= '0;
			end else if (state_q == ST_LDIV) begin
				lcnt_q <= lcnt_q + 1'b1;
			end
			if ((state_q == ST_DEC2) && lower_go) begin
				tcnt_q <= '0;
			end else if (state_q == ST_TDIV) begin
				tcnt_q <= tcnt_q + 1'b1;
			end
			if ((state_q == ST_ACC) && (lf > mlf_q)) begin
				mlf_q <= lf;
			end else if (emit_fire) begin
				mlf_q <= '0;
			end
			if (state_q == ST_DEC2) begin
				if (raise_q && (cur_q < fmax_q)) begin
					rate_q <= hold_eff;
				end else if (lower_go) begin
					rate_q <= HOLD_ONE;
				end
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CORES; i++) begin
				prev_wall_q[i] <= '0;
				prev_idle_q[i] <= '0;
				prev_iow_q[i]  <= '0;
				prev_nice_q[i] <= '0;
			end
		end else if (rec_en) begin
			prev_wall_q[sample.core_index] <= sample.wall_us[DELTA_W-1:0];
			prev_idle_q[sample.core_index] <= sample.idle_us[DELTA_W-1:0];
			prev_iow_q[sample.core_index]  <= sample.iowait_us[DELTA_W-1:0];
			prev_nice_q[sample.core_index] <= sample.nice_us[DELTA_W-1:0];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= sample.cur_freq_khz;
			favg_q <= (sample.avg_freq_khz == '0) ? sample.cur_freq_khz : sample.avg_freq_khz;
			last_q <= sample.last_core;
		end
		case (state_q)
			ST_PREP: begin
				num_q  <= NUM_W'(dbusy) * NUM_W'(LOAD_SCALE);
				den_q  <= NUM_W'(dwall) << (LOAD_W - 1);
				load_q <= '0;
			end
			ST_LDIV: begin
				if (ld_ge) begin
					num_q <= num_q - den_q;
				end
				den_q  <= den_q >> 1;
				load_q <= {load_q[LOAD_W-2:0], ld_ge};
			end
			ST_CHECK: prod_q <= LF_W'(up_q) * LF_W'(cur_q);
			ST_DEC1: begin
				raise_q <= mlf_q > prod_q;
				prod_q  <= LF_W'(diff) * LF_W'(cur_q);
			end
			ST_DEC2: begin
				if (raise_q) begin
					dec_act_q <= (cur_q != fmax_q) ? ACT_RAISE : ACT_NONE;
					dec_tgt_q <= (cur_q != fmax_q) ? fmax_q : '0;
				end else if (lower_go) begin
					dec_act_q <= ACT_LOWER;
					dec_tgt_q <= '0;
				end else begin
					dec_act_q <= ACT_NONE;
					dec_tgt_q <= '0;
				end
				// quotient fits the frequency width, so the top bits start as remainder
				trem_q <= mlf_q[FREQ_W +: PCT_W];
				tnum_q <= mlf_q[FREQ_W-1:0];
				tquo_q <= '0;
			end
			ST_TDIV: begin
				trem_q <= td_rem[PCT_W-1:0];
				tnum_q <= tnum_q << 1;
				tquo_q <= {tquo_q[FREQ_W-2:0], td_ge};
			end
			default: ;
		endcase
		if (emit_fire) begin
			res_action_q <= dec_act_q;
			res_target_q <= (dec_act_q == ACT_LOWER) ? lower_tgt : dec_tgt_q;
			res_rate_q   <= rate_q;
		end
	end

	assign sample.ready           = (state_q == ST_IDLE);
	assign result.valid           = out_valid_q;
	assign result.action          = res_action_q;
	assign result.target_khz      = res_target_q;
	assign result.rate_multiplier = res_rate_q;

	`ASSERT_ALWAYS(a_rate_range, clk, arst_n, (rate_q != '0) && (rate_q <= HOLD_MAX))
	`ASSERT_NEXT(a_peak_cleared, clk, arst_n, emit_fire, mlf_q == '0)
	`ASSERT_IMP(a_load_pct, clk, arst_n, state_q == ST_ACC, load_q <= LOAD_SCALE)
	`ASSERT_IMP(a_trem_bound, clk, arst_n, state_q == ST_TDIV, trem_q < diff)

endmodule

FILE: hw/rtl/lbfg_delta.sv
// Bit-serial counter delta unit: wall delta and busy time, one bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbfg_delta (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          nice_idle,
	input  logic                          iow_busy,
	input  logic [lbfg_pkg::DELTA_W-1:0]  cur_wall,
	input  logic [lbfg_pkg::DELTA_W-1:0]  prev_wall,
	input  logic [lbfg_pkg::DELTA_W-1:0]  cur_idle,
	input  logic [lbfg_pkg::DELTA_W-1:0]  prev_idle,
	input  logic [lbfg_pkg::DELTA_W-1:0]  cur_iow,
	input  logic [lbfg_pkg::DELTA_W-1:0]  prev_iow,
	input  logic [lbfg_pkg::DELTA_W-1:0]  now_nice,
	input  logic [lbfg_pkg::DELTA_W-1:0]  prev_nice,
	output logic [lbfg_pkg::DELTA_W-1:0]  wall,
	output logic [lbfg_pkg::DELTA_W-1:0]  busy,
	output lbfg_pkg::delta_stat_t         stat
);
	import lbfg_pkg::*;

	// {borrow out, difference bit}
	function automatic logic [1:0] sub_bit(input logic a, input logic b, input logic bi);
		return {(~a & b) | (~(a ^ b) & bi), a ^ b ^ bi};
	endfunction

	// {carry out, sum bit}
	function automatic logic [1:0] add_bit(input logic a, input logic b, input logic ci);
		return {(a & b) | (a & ci) | (b & ci), a ^ b ^ ci};
	endfunction

	logic [DELTA_W-1:0] cw_q, pw_q, ci_q, pi_q, co_q, po_q, cn_q, pn_q;
	logic [DELTA_W-1:0] wall_q, bs_q, bt_q;
	logic bw_w_q, bw_i_q, bw_o_q, bw_n_q, cy_s_q, bw_t_q, bw_bs_q, bw_bt_q, nz_q;
	logic run_q, done_q;
	logic [DBIT_W-1:0] cnt_q;

	logic w_b, i_b, o_b, n_b, s_b, t_b, bs_b, bt_b;
	logic bw_w_d, bw_i_d, bw_o_d, bw_n_d, cy_s_d, bw_t_d, bw_bs_d, bw_bt_d;
	logic use_t;

	always_comb begin
		{bw_w_d, w_b}   = sub_bit(cw_q[0], pw_q[0], bw_w_q);
		{bw_i_d, i_b}   = sub_bit(ci_q[0], pi_q[0], bw_i_q);
		{bw_o_d, o_b}   = sub_bit(co_q[0], po_q[0], bw_o_q);
		{bw_n_d, n_b}   = sub_bit(cn_q[0], pn_q[0], bw_n_q);
		{cy_s_d, s_b}   = add_bit(i_b, n_b & nice_idle, cy_s_q);
		{bw_t_d, t_b}   = sub_bit(s_b, o_b, bw_t_q);
		{bw_bs_d, bs_b} = sub_bit(w_b, s_b, bw_bs_q);
		{bw_bt_d, bt_b} = sub_bit(w_b, t_b, bw_bt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == BIT_LAST);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BIT_LAST) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cw_q    <= cur_wall;
			pw_q    <= prev_wall;
			ci_q    <= cur_idle;
			pi_q    <= prev_idle;
			co_q    <= cur_iow;
			po_q    <= prev_iow;
			cn_q    <= now_nice;
			pn_q    <= prev_nice;
			bw_w_q  <= 1'b0;
			bw_i_q  <= 1'b0;
			bw_o_q  <= 1'b0;
			bw_n_q  <= 1'b0;
			cy_s_q  <= 1'b0;
			bw_t_q  <= 1'b0;
			bw_bs_q <= 1'b0;
			bw_bt_q <= 1'b0;
			nz_q    <= 1'b0;
		end else if (run_q) begin
			cw_q    <= cw_q >> 1;
			pw_q    <= pw_q >> 1;
			ci_q    <= ci_q >> 1;
			pi_q    <= pi_q >> 1;
			co_q    <= co_q >> 1;
			po_q    <= po_q >> 1;
			cn_q    <= cn_q >> 1;
			pn_q    <= pn_q >> 1;
			wall_q  <= {w_b, wall_q[DELTA_W-1:1]};
			bs_q    <= {bs_b, bs_q[DELTA_W-1:1]};
			bt_q    <= {bt_b, bt_q[DELTA_W-1:1]};
			bw_w_q  <= bw_w_d;
			bw_i_q  <= bw_i_d;
			bw_o_q  <= bw_o_d;
			bw_n_q  <= bw_n_d;
			cy_s_q  <= cy_s_d;
			bw_t_q  <= bw_t_d;
			bw_bs_q <= bw_bs_d;
			bw_bt_q <= bw_bt_d;
			nz_q    <= nz_q | w_b;
		end
	end

	// with iow_busy set, iowait comes off idle only when idle covers it
	assign use_t       = iow_busy & ~bw_t_q;
	assign wall        = wall_q;
	assign busy        = use_t ? bt_q : bs_q;
	assign stat.done   = done_q;
	assign stat.usable = nz_q & ~(use_t ? bw_bt_q : bw_bs_q);

	`ASSERT_NEXT(a_start_runs, clk, arst_n, start, run_q)
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`ASSERT_NEXT(a_done_after_last, clk, arst_n, run_q && (cnt_q == BIT_LAST), done_q)

endmodule
